/* src/gacx_pkg.sv */
package gacx_pkg;

    // Default sizing of the gene stream
    localparam int MAX_CHROM_LEN_DEF = 1024;
    localparam int GENE_WIDTH_DEF    = 16;
    localparam int RAND_BITS_DEF     = 16;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int PROB_W   = 17;
    localparam int LEN_W    = 11;
    localparam int SWAPS_W  = 11;
    localparam int COUNT_W  = 32;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Crossover modes
    localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEGMENT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNIFORM  = 2'd2;

    // Register indexes (byte address is four times the index)
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_CROSS_PROB = 2'd1;
    localparam logic [1:0] REG_SWAP_PROB  = 2'd2;
    localparam logic [1:0] REG_CHROM_LEN  = 2'd3;

    // Register reset values
    localparam logic [MODE_W-1:0] MODE_RST       = MODE_SINGLE;
    localparam logic [PROB_W-1:0] CROSS_PROB_RST = 17'd58982;
    localparam logic [PROB_W-1:0] SWAP_PROB_RST  = 17'd32768;
    localparam logic [LEN_W-1:0]  CHROM_LEN_RST  = 11'd64;

    // Swap counter limit per pair
    localparam logic [SWAPS_W-1:0] SWAPS_LIMIT = {SWAPS_W{1'b1}};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PROB_W-1:0] cross_prob;
        logic [PROB_W-1:0] swap_prob;
        logic [LEN_W-1:0]  chrom_length;
    } t_cfg;

endpackage

/* src/gacx_regs.sv */
module gacx_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gacx_pkg::ADDR_W-1:0] paddr,
    input  logic [gacx_pkg::DATA_W-1:0] pwdata,
    output logic [gacx_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output gacx_pkg::t_cfg              o_cfg
);
    import gacx_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_index;

    assign w_index = paddr[3:2];
    assign w_wr    = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write a register in the access phase of a write request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_RST;
            r_cfg.cross_prob   <= CROSS_PROB_RST;
            r_cfg.swap_prob    <= SWAP_PROB_RST;
            r_cfg.chrom_length <= CHROM_LEN_RST;
        end else if (w_wr) begin
            unique case (w_index)
                REG_MODE:       r_cfg.mode         <= pwdata[MODE_W-1:0];
                REG_CROSS_PROB: r_cfg.cross_prob   <= pwdata[PROB_W-1:0];
                REG_SWAP_PROB:  r_cfg.swap_prob    <= pwdata[PROB_W-1:0];
                REG_CHROM_LEN:  r_cfg.chrom_length <= pwdata[LEN_W-1:0];
            endcase
        end
    end

    // Return the addressed register on a read request
    always_comb begin
        prdata = '0;
        unique case (w_index)
            REG_MODE:       prdata[MODE_W-1:0] = r_cfg.mode;
            REG_CROSS_PROB: prdata[PROB_W-1:0] = r_cfg.cross_prob;
            REG_SWAP_PROB:  prdata[PROB_W-1:0] = r_cfg.swap_prob;
            REG_CHROM_LEN:  prdata[LEN_W-1:0]  = r_cfg.chrom_length;
        endcase
    end

endmodule

/* src/ga_chromosome_crossover.sv */
// Crossover of one parent pair, streamed one gene position per request. Each
// accepted request gives exactly one result, through the input register and
// then the result register, and a new request is taken in every cycle while
// the block does not stall: the per-position state (position counters, cut
// points, swap count) updates in one step as an item leaves the input
// register, and the cut points come from one small multiplier each at pair or
// segment start. The block stalls only when its result register is full and
// held by the consumer. Configure mode, probabilities and chromosome length
// through the register port while no item is in flight.
module ga_chromosome_crossover #(
    parameter int MAX_CHROM_LEN = gacx_pkg::MAX_CHROM_LEN_DEF,
    parameter int GENE_WIDTH    = gacx_pkg::GENE_WIDTH_DEF,
    parameter int RAND_BITS     = gacx_pkg::RAND_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gacx_pkg::ADDR_W-1:0]  paddr,
    input  logic [gacx_pkg::DATA_W-1:0]  pwdata,
    output logic [gacx_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // gene input
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [GENE_WIDTH-1:0]        i_gene_a,
    input  logic [GENE_WIDTH-1:0]        i_gene_b,
    input  logic                         i_last_gene,
    input  logic                         i_segment_first,
    input  logic [gacx_pkg::LEN_W-1:0]   i_segment_length,
    input  logic [RAND_BITS-1:0]         i_rand_pair,
    input  logic [RAND_BITS-1:0]         i_rand_site,
    input  logic [RAND_BITS-1:0]         i_rand_gene,
    // offspring output
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [GENE_WIDTH-1:0]        o_child_a,
    output logic [GENE_WIDTH-1:0]        o_child_b,
    output logic                         o_swapped,
    output logic                         o_last_out,
    output logic                         o_pair_crossed,
    output logic                         o_pair_changed,
    output logic [gacx_pkg::COUNT_W-1:0] o_cross_count
);
    import gacx_pkg::*;

    localparam int POS_W  = $clog2(2 * MAX_CHROM_LEN);
    localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int PCMP_W = (RAND_BITS > PROB_W) ? RAND_BITS : PROB_W;
    localparam int PROD_W = RAND_BITS + LEN_W;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(2 * MAX_CHROM_LEN - 1);

    t_cfg w_cfg;

    gacx_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register
    logic                  r_s1_valid;
    logic [GENE_WIDTH-1:0] r_s1_gene_a;
    logic [GENE_WIDTH-1:0] r_s1_gene_b;
    logic                  r_s1_last;
    logic                  r_s1_seg_first;
    logic [LEN_W-1:0]      r_s1_seg_len;
    logic [RAND_BITS-1:0]  r_s1_rand_pair;
    logic [RAND_BITS-1:0]  r_s1_rand_site;
    logic [RAND_BITS-1:0]  r_s1_rand_gene;

    // Pair state
    logic                  r_at_pair_start;
    logic                  r_crossing;
    logic [POS_W-1:0]      r_position;
    logic [LEN_W-1:0]      r_cut_point;
    logic [POS_W-1:0]      r_segment_position;
    logic [LEN_W-1:0]      r_segment_cut;
    logic [SWAPS_W-1:0]    r_pair_swaps;
    logic [COUNT_W-1:0]    r_cross_total;

    // Result register
    logic                  r_out_valid;
    logic [GENE_WIDTH-1:0] r_child_a;
    logic [GENE_WIDTH-1:0] r_child_b;
    logic                  r_swapped;
    logic                  r_last_out;
    logic                  r_pair_crossed;
    logic                  r_pair_changed;

    logic w_out_free;
    logic w_advance;
    logic w_accept;

    // Advance when the result register is empty or being taken
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture an accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_gene_a    <= i_gene_a;
            r_s1_gene_b    <= i_gene_b;
            r_s1_last      <= i_last_gene;
            r_s1_seg_first <= i_segment_first;
            r_s1_seg_len   <= i_segment_length;
            r_s1_rand_pair <= i_rand_pair;
            r_s1_rand_site <= i_rand_site;
            r_s1_rand_gene <= i_rand_gene;
        end
    end

    // Scale the site fraction to cut points
    logic [PROD_W-1:0] w_prod_chrom;
    logic [PROD_W-1:0] w_prod_seg;

    assign w_prod_chrom = {{LEN_W{1'b0}}, r_s1_rand_site} *
                          {{RAND_BITS{1'b0}}, w_cfg.chrom_length};
    assign w_prod_seg   = {{LEN_W{1'b0}}, r_s1_rand_site} *
                          {{RAND_BITS{1'b0}}, r_s1_seg_len};

    // Decide the swap and the next pair state
    logic                  w_crossing;
    logic [POS_W-1:0]      w_pos;
    logic [LEN_W-1:0]      w_cut;
    logic [POS_W-1:0]      w_seg_pos;
    logic [LEN_W-1:0]      w_seg_cut;
    logic [SWAPS_W-1:0]    w_swaps_cur;
    logic [SWAPS_W-1:0]    w_swaps;
    logic                  w_swap;
    logic                  w_changed;
    logic                  w_count_end;
    logic [SWAPS_W-1:0]    w_count_inc;
    logic [COUNT_W:0]      w_total_sum;
    logic [COUNT_W-1:0]    w_total;
    logic [POS_W-1:0]      n_position;
    logic [POS_W-1:0]      n_segment_position;

    always_comb begin
        w_crossing  = r_at_pair_start
                    ? (PCMP_W'(r_s1_rand_pair) < PCMP_W'(w_cfg.cross_prob))
                    : r_crossing;
        w_pos       = r_at_pair_start ? '0 : r_position;
        w_cut       = r_at_pair_start ? w_prod_chrom[PROD_W-1:RAND_BITS] : r_cut_point;
        w_seg_pos   = (r_at_pair_start || r_s1_seg_first) ? '0 : r_segment_position;
        if (r_s1_seg_first) begin
            w_seg_cut = w_prod_seg[PROD_W-1:RAND_BITS];
        end else begin
            w_seg_cut = r_at_pair_start ? '0 : r_segment_cut;
        end
        w_swaps_cur = r_at_pair_start ? '0 : r_pair_swaps;

        w_swap = 1'b0;
        if (w_crossing) begin
            unique case (w_cfg.mode)
                MODE_SINGLE:  w_swap = CMP_W'(w_pos) >= CMP_W'(w_cut);
                MODE_SEGMENT: w_swap = CMP_W'(w_seg_pos) >= CMP_W'(w_seg_cut);
                MODE_UNIFORM: w_swap = (PCMP_W'(r_s1_rand_gene) <= PCMP_W'(w_cfg.swap_prob))
                                    && (r_s1_gene_a != r_s1_gene_b);
                default:      w_swap = 1'b0;
            endcase
        end

        w_swaps = w_swaps_cur;
        if (w_cfg.mode == MODE_UNIFORM && w_swap && w_swaps_cur != SWAPS_LIMIT) begin
            w_swaps = w_swaps_cur + 1'b1;
        end

        // Count once per crossing pair, or by the swaps at a uniform pair end
        w_count_end = (w_cfg.mode == MODE_UNIFORM) && r_s1_last;
        w_changed   = w_count_end && (w_swaps != '0);
        if (w_count_end) begin
            w_count_inc = w_swaps;
        end else if (r_at_pair_start && w_crossing &&
                     (w_cfg.mode == MODE_SINGLE || w_cfg.mode == MODE_SEGMENT)) begin
            w_count_inc = SWAPS_W'(1);
        end else begin
            w_count_inc = '0;
        end
        w_total_sum = {1'b0, r_cross_total} + (COUNT_W + 1)'(w_count_inc);
        w_total     = w_total_sum[COUNT_W] ? {COUNT_W{1'b1}} : w_total_sum[COUNT_W-1:0];

        // Advance the position counters unless the pair ends here
        if (r_s1_last) begin
            n_position         = w_pos;
            n_segment_position = w_seg_pos;
        end else begin
            n_position         = (w_pos >= POS_LIMIT) ? POS_LIMIT : w_pos + 1'b1;
            n_segment_position = (w_seg_pos >= POS_LIMIT) ? POS_LIMIT : w_seg_pos + 1'b1;
        end
    end

    // Update the pair state as an item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_pair_start    <= 1'b1;
            r_crossing         <= 1'b0;
            r_position         <= '0;
            r_cut_point        <= '0;
            r_segment_position <= '0;
            r_segment_cut      <= '0;
            r_pair_swaps       <= '0;
            r_cross_total      <= '0;
        end else if (w_advance) begin
            r_at_pair_start    <= r_s1_last;
            r_crossing         <= w_crossing;
            r_position         <= n_position;
            r_cut_point        <= w_cut;
            r_segment_position <= n_segment_position;
            r_segment_cut      <= w_seg_cut;
            r_pair_swaps       <= w_swaps;
            r_cross_total      <= w_total;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_child_a      <= w_swap ? r_s1_gene_b : r_s1_gene_a;
            r_child_b      <= w_swap ? r_s1_gene_a : r_s1_gene_b;
            r_swapped      <= w_swap;
            r_last_out     <= r_s1_last;
            r_pair_crossed <= w_crossing;
            r_pair_changed <= w_changed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_child_a      = r_child_a;
    assign o_child_b      = r_child_b;
    assign o_swapped      = r_swapped;
    assign o_last_out     = r_last_out;
    assign o_pair_crossed = r_pair_crossed;
    assign o_pair_changed = r_pair_changed;
    assign o_cross_count  = r_cross_total;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import gacx_pkg::*;

    localparam int GW           = GENE_WIDTH_DEF;
    localparam int RW           = RAND_BITS_DEF;
    localparam int RANDOM_ITEMS = 650;
    localparam int LONG_PAIR    = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
    localparam logic [LEN_W-1:0]  POS_CAP   = 11'd2047;
    localparam logic [SWAPS_W-1:0] SWAP_CAP = 11'd2047;

    typedef struct {
        logic [GW-1:0]    gene_a;
        logic [GW-1:0]    gene_b;
        logic             last;
        logic             seg_first;
        logic [LEN_W-1:0] seg_len;
        logic [RW-1:0]    rand_pair;
        logic [RW-1:0]    rand_site;
        logic [RW-1:0]    rand_gene;
    } gene_req_t;

    typedef struct {
        logic [GW-1:0]      child_a;
        logic [GW-1:0]      child_b;
        logic               swapped;
        logic               last_out;
        logic               crossed;
        logic               changed;
        logic [COUNT_W-1:0] count;
    } offspring_t;

    // DUT stimulus, all known from time zero
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [ADDR_W-1:0]   paddr            = '0;
    logic [DATA_W-1:0]   pwdata           = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid          = 1'b0;
    logic                o_stall;
    logic [GW-1:0]       i_gene_a         = '0;
    logic [GW-1:0]       i_gene_b         = '0;
    logic                i_last_gene      = 1'b0;
    logic                i_segment_first  = 1'b0;
    logic [LEN_W-1:0]    i_segment_length = '0;
    logic [RW-1:0]       i_rand_pair      = '0;
    logic [RW-1:0]       i_rand_site      = '0;
    logic [RW-1:0]       i_rand_gene      = '0;
    logic                o_valid;
    logic                i_stall          = 1'b0;
    logic [GW-1:0]       o_child_a;
    logic [GW-1:0]       o_child_b;
    logic                o_swapped;
    logic                o_last_out;
    logic                o_pair_crossed;
    logic                o_pair_changed;
    logic [COUNT_W-1:0]  o_cross_count;

    // Register mirror
    logic [MODE_W-1:0]  cfg_mode;
    logic [PROB_W-1:0]  cfg_cross_prob;
    logic [PROB_W-1:0]  cfg_swap_prob;
    logic [LEN_W-1:0]   cfg_chrom_len;

    // Crossover state mirror
    logic               pr_at_start;
    logic               pr_crossing;
    logic [LEN_W-1:0]   pr_pos;
    logic [LEN_W-1:0]   pr_cut;
    logic [LEN_W-1:0]   pr_seg_pos;
    logic [LEN_W-1:0]   pr_seg_cut;
    logic [SWAPS_W-1:0] pr_swaps;
    logic [COUNT_W-1:0] pr_total;

    offspring_t offspring_q[$];
    int  err_count    = 0;
    int  rnd_sent     = 0;
    int  tx_gap_odds  = 4;
    int  rx_hold_left = 0;
    int  rx_run_left  = 0;
    int  rx_pick      = 0;
    bit  no_idle      = 1'b0;

    ga_chromosome_crossover u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_gene_a         (i_gene_a),
        .i_gene_b         (i_gene_b),
        .i_last_gene      (i_last_gene),
        .i_segment_first  (i_segment_first),
        .i_segment_length (i_segment_length),
        .i_rand_pair      (i_rand_pair),
        .i_rand_site      (i_rand_site),
        .i_rand_gene      (i_rand_gene),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_child_a        (o_child_a),
        .o_child_b        (o_child_b),
        .o_swapped        (o_swapped),
        .o_last_out       (o_last_out),
        .o_pair_crossed   (o_pair_crossed),
        .o_pair_changed   (o_pair_changed),
        .o_cross_count    (o_cross_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Offspring prediction
    // ------------------------------------------------------------------
    function automatic logic [LEN_W-1:0] cut_of(input logic [RW-1:0] frac,
                                                 input logic [LEN_W-1:0] len);
        logic [RW+LEN_W-1:0] prod;
        prod = frac * len;
        return prod[RW+LEN_W-1:RW];
    endfunction

    function automatic logic [COUNT_W-1:0] add_sat32(input logic [COUNT_W-1:0] a,
                                                     input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] bump_pos(input logic [LEN_W-1:0] p);
        return (p >= POS_CAP) ? POS_CAP : p + 11'd1;
    endfunction

    task automatic reset_predictor();
        cfg_mode       = MODE_RST;
        cfg_cross_prob = CROSS_PROB_RST;
        cfg_swap_prob  = SWAP_PROB_RST;
        cfg_chrom_len  = CHROM_LEN_RST;
        pr_at_start    = 1'b1;
        pr_crossing    = 1'b0;
        pr_pos         = '0;
        pr_cut         = '0;
        pr_seg_pos     = '0;
        pr_seg_cut     = '0;
        pr_swaps       = '0;
        pr_total       = '0;
    endtask

    task automatic predict_offspring(input gene_req_t r, output offspring_t o);
        logic swp;
        logic chg;
        swp = 1'b0;
        chg = 1'b0;
        // decide crossing and draw the whole-chromosome cut at pair start
        if (pr_at_start) begin
            pr_crossing = ({1'b0, r.rand_pair} < cfg_cross_prob);
            pr_pos      = '0;
            pr_swaps    = '0;
            pr_cut      = cut_of(r.rand_site, cfg_chrom_len);
            pr_seg_pos  = '0;
            pr_seg_cut  = '0;
            if (pr_crossing && (cfg_mode == MODE_SINGLE || cfg_mode == MODE_SEGMENT))
                pr_total = add_sat32(pr_total, 32'd1);
        end
        // restart the segment on a mark
        if (r.seg_first) begin
            pr_seg_pos = '0;
            pr_seg_cut = cut_of(r.rand_site, r.seg_len);
        end
        if (pr_crossing) begin
            case (cfg_mode)
                MODE_SINGLE: begin
                    swp = (pr_pos >= pr_cut);
                end
                MODE_SEGMENT: begin
                    swp = (pr_seg_pos >= pr_seg_cut);
                end
                MODE_UNIFORM: begin
                    swp = ({1'b0, r.rand_gene} <= cfg_swap_prob) && (r.gene_a != r.gene_b);
                    if (swp && pr_swaps != SWAP_CAP)
                        pr_swaps = pr_swaps + 11'd1;
                end
                default: begin
                end
            endcase
        end
        // fold the pair's swaps into the count at its last gene
        if (cfg_mode == MODE_UNIFORM && r.last) begin
            chg      = (pr_swaps != '0);
            pr_total = add_sat32(pr_total, {{(COUNT_W-SWAPS_W){1'b0}}, pr_swaps});
        end
        o.child_a  = swp ? r.gene_b : r.gene_a;
        o.child_b  = swp ? r.gene_a : r.gene_b;
        o.swapped  = swp;
        o.last_out = r.last;
        o.crossed  = pr_crossing;
        o.changed  = chg;
        o.count    = pr_total;
        // advance position counters
        if (r.last) begin
            pr_at_start = 1'b1;
        end else begin
            pr_at_start = 1'b0;
            pr_pos      = bump_pos(pr_pos);
            pr_seg_pos  = bump_pos(pr_seg_pos);
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_offspring
        offspring_t e;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (offspring_q.size() == 0) begin
                report_mismatch("result with no request pending", o_child_a, 0);
            end else begin
                e = offspring_q.pop_front();
                check_field("child_a", o_child_a, e.child_a);
                check_field("child_b", o_child_b, e.child_b);
                check_field("swapped", o_swapped, e.swapped);
                check_field("last_out", o_last_out, e.last_out);
                check_field("pair_crossed", o_pair_crossed, e.crossed);
                check_field("pair_changed", o_pair_changed, e.changed);
                check_field("cross_count", o_cross_count, e.count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: long hold-offs first, then random bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else if (rx_run_left > 0) begin
            rx_run_left = rx_run_left - 1;
        end else begin
            rx_pick = $urandom_range(0, 9);
            if (rx_pick < 3) begin
                i_stall <= 1'b1;
                rx_run_left = $urandom_range(0, 17);
            end else if (rx_pick < 9) begin
                i_stall <= 1'b0;
                rx_run_left = $urandom_range(0, 17);
            end else begin
                i_stall <= 1'b0;
                rx_run_left = $urandom_range(40, 150);
            end
        end
    end

    // ------------------------------------------------------------------
    // Register port and request sender
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:       cfg_mode       = val[MODE_W-1:0];
            REG_CROSS_PROB: cfg_cross_prob = val[PROB_W-1:0];
            REG_SWAP_PROB:  cfg_swap_prob  = val[PROB_W-1:0];
            REG_CHROM_LEN:  cfg_chrom_len  = val[LEN_W-1:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_gene(input gene_req_t r);
        offspring_t o;
        int gap;
        gap = 0;
        if (!no_idle && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1)
            gap = $urandom_range(1, 18);
        // drop valid for an idle burst
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_gene_a         <= r.gene_a;
        i_gene_b         <= r.gene_b;
        i_last_gene      <= r.last;
        i_segment_first  <= r.seg_first;
        i_segment_length <= r.seg_len;
        i_rand_pair      <= r.rand_pair;
        i_rand_site      <= r.rand_site;
        i_rand_gene      <= r.rand_gene;
        // hold until the request is taken
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_offspring(r, o);
        offspring_q.push_back(o);
    endtask

    // Stop sending and wait until every result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (offspring_q.size() != 0);
    endtask

    function automatic gene_req_t mk_gene(input logic [GW-1:0] ga, gb,
                                          input logic last, sf,
                                          input logic [LEN_W-1:0] sl,
                                          input logic [RW-1:0] rp, rs, rg);
        gene_req_t r;
        r.gene_a    = ga;
        r.gene_b    = gb;
        r.last      = last;
        r.seg_first = sf;
        r.seg_len   = sl;
        r.rand_pair = rp;
        r.rand_site = rs;
        r.rand_gene = rg;
        return r;
    endfunction

    function automatic logic [15:0] rand16();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic gene_req_t rand_item();
        gene_req_t r;
        r.gene_a    = rand16();
        r.gene_b    = ($urandom_range(0, 4) == 0) ? r.gene_a : rand16();
        r.last      = 1'b0;
        r.seg_first = 1'($urandom_range(0, 1));
        r.seg_len   = LEN_W'($urandom_range(0, 2047));
        r.rand_pair = rand16();
        r.rand_site = rand16();
        r.rand_gene = rand16();
        return r;
    endfunction

    function automatic logic [31:0] pick_prob();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd65536;
            2:       return 32'd131071;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // Send one parent pair; in segment mode mark segments, with some noise
    task automatic send_pair(input int len);
        gene_req_t it;
        int seg_left;
        seg_left = 0;
        for (int i = 0; i < len; i++) begin
            it      = rand_item();
            it.last = (i == len - 1);
            if (cfg_mode == MODE_SEGMENT) begin
                it.seg_first = 1'b0;
                if (seg_left == 0 && $urandom_range(0, 7) != 0) begin
                    seg_left     = $urandom_range(1, 12);
                    it.seg_first = 1'b1;
                    if ($urandom_range(0, 5) != 0)
                        it.seg_len = LEN_W'(seg_left);
                end
                if (seg_left > 0)
                    seg_left--;
                if ($urandom_range(0, 24) == 0)
                    it.seg_first = ~it.seg_first;
            end
            send_gene(it);
            rnd_sent++;
        end
    endtask

    task automatic set_random_config();
        int k;
        k = $urandom_range(0, 9);
        write_reg(REG_MODE, (k < 3) ? MODE_SINGLE : (k < 6) ? MODE_SEGMENT :
                            (k < 9) ? MODE_UNIFORM : MODE_RSVD);
        write_reg(REG_CROSS_PROB, pick_prob());
        write_reg(REG_SWAP_PROB, pick_prob());
        k = $urandom_range(0, 9);
        write_reg(REG_CHROM_LEN, (k == 0) ? 0 : (k == 1) ? 2047 :
                                 (k == 2) ? $urandom_range(0, 2047) : $urandom_range(1, 64));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset register values: crossing pair with a cut at 2, then a pair that fails
    task automatic test_reset_defaults();
        send_gene(mk_gene(16'h0000, 16'hFFFF, 0, 0, 11'd0, 16'h0000, 16'h0800, 16'h0));
        send_gene(mk_gene(16'hFFFF, 16'h0000, 0, 0, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_gene(mk_gene(16'h1234, 16'hABCD, 0, 1, 11'd2047, 16'h0, 16'h0, 16'h0));
        send_gene(mk_gene(16'hFFFF, 16'hFFFF, 1, 0, 11'd0, 16'h0, 16'h0, 16'h0));
        send_gene(mk_gene(16'h5A5A, 16'hA5A5, 1, 0, 11'd0, 16'hFFFF, 16'h0, 16'h0));
    endtask

    // Zero length gives a cut at 0; zero cross probability never crosses
    task automatic test_single_point();
        wait_drained();
        write_reg(REG_CHROM_LEN, 0);
        write_reg(REG_CROSS_PROB, 65536);
        send_gene(mk_gene(16'h0001, 16'h8000, 0, 0, 11'd0, 16'hFFFF, 16'hFFFF, 16'h0));
        send_gene(mk_gene(16'h7FFF, 16'h0002, 1, 0, 11'd0, 16'h0, 16'h0, 16'h0));
        wait_drained();
        write_reg(REG_CHROM_LEN, 2047);
        write_reg(REG_CROSS_PROB, 0);
        send_gene(mk_gene(16'h1111, 16'h2222, 1, 0, 11'd0, 16'h0000, 16'hFFFF, 16'h0));
    endtask

    // Unmarked pair start, a marked segment overrun, and a zero-length segment
    task automatic test_segments();
        wait_drained();
        write_reg(REG_MODE, MODE_SEGMENT);
        write_reg(REG_CROSS_PROB, 65536);
        write_reg(REG_CHROM_LEN, 64);
        send_gene(mk_gene(16'h0A0A, 16'hB0B0, 0, 0, 11'd9, 16'h0, 16'hFFFF, 16'h0));
        send_gene(mk_gene(16'h0C0C, 16'hD0D0, 0, 1, 11'd4, 16'h0, 16'hFFFF, 16'h0));
        send_gene(mk_gene(16'h0E0E, 16'hF0F0, 0, 0, 11'd0, 16'h0, 16'h0, 16'h0));
        send_gene(mk_gene(16'h1010, 16'h2020, 0, 0, 11'd0, 16'h0, 16'h0, 16'h0));
        send_gene(mk_gene(16'h3030, 16'h4040, 0, 0, 11'd0, 16'h0, 16'h0, 16'h0));
        send_gene(mk_gene(16'h5050, 16'h6060, 1, 0, 11'd0, 16'h0, 16'h0, 16'h0));
        send_gene(mk_gene(16'h7070, 16'h8080, 1, 1, 11'd0, 16'h0, 16'hFFFF, 16'h0));
    endtask

    // Uniform swap at the probability edges, equal genes never swap
    task automatic test_uniform();
        wait_drained();
        write_reg(REG_MODE, MODE_UNIFORM);
        write_reg(REG_SWAP_PROB, 0);
        send_gene(mk_gene(16'h0001, 16'h0002, 0, 0, 11'd0, 16'h0, 16'h0, 16'h0000));
        send_gene(mk_gene(16'h0003, 16'h0004, 0, 0, 11'd0, 16'h0, 16'h0, 16'h0001));
        send_gene(mk_gene(16'h9999, 16'h9999, 1, 0, 11'd0, 16'h0, 16'h0, 16'h0000));
        wait_drained();
        write_reg(REG_SWAP_PROB, 65536);
        send_gene(mk_gene(16'hCAFE, 16'hCAFE, 1, 0, 11'd0, 16'h0, 16'h0, 16'hFFFF));
    endtask

    // Reserved mode passes genes through
    task automatic test_reserved_mode();
        wait_drained();
        write_reg(REG_MODE, MODE_RSVD);
        send_gene(mk_gene(16'h1357, 16'h2468, 0, 1, 11'd1, 16'h0, 16'h0, 16'h0));
        send_gene(mk_gene(16'hFFFF, 16'h0000, 1, 0, 11'd0, 16'h0, 16'h0, 16'h0));
    endtask

    // Switch from single point to uniform in the middle of a pair
    task automatic test_mode_switch();
        wait_drained();
        write_reg(REG_MODE, MODE_SINGLE);
        write_reg(REG_CHROM_LEN, 4);
        send_gene(mk_gene(16'h0011, 16'h0022, 0, 0, 11'd0, 16'h0, 16'h8000, 16'h0));
        send_gene(mk_gene(16'h0033, 16'h0044, 0, 0, 11'd0, 16'h0, 16'h0, 16'h0));
        wait_drained();
        write_reg(REG_MODE, MODE_UNIFORM);
        send_gene(mk_gene(16'h0055, 16'h0066, 0, 0, 11'd0, 16'h0, 16'h0, 16'h8000));
        send_gene(mk_gene(16'h0077, 16'h0088, 1, 0, 11'd0, 16'h0, 16'h0, 16'hFFFF));
    endtask

    // Long pairs in each mode, with the cut half way along the pair in single and segment mode
    task automatic test_long_pairs();
        gene_req_t it;
        wait_drained();
        write_reg(REG_CROSS_PROB, 65536);
        write_reg(REG_SWAP_PROB, 65536);
        write_reg(REG_CHROM_LEN, LONG_PAIR);
        for (int m = 0; m < 3; m++) begin
            wait_drained();
            write_reg(REG_MODE, (m == 0) ? MODE_SINGLE : (m == 1) ? MODE_SEGMENT : MODE_UNIFORM);
            for (int i = 0; i < LONG_PAIR; i++) begin
                it           = rand_item();
                it.gene_b    = it.gene_a ^ (rand16() | 16'h0001);
                it.seg_first = (i == 0);
                it.seg_len   = LEN_W'(LONG_PAIR);
                it.rand_site = 16'h8000;
                it.last      = (i == LONG_PAIR - 1);
                send_gene(it);
            end
        end
    endtask

    // Receiver holds off so the block fills; then the sender waits for all results
    task automatic test_backpressure();
        wait_drained();
        set_random_config();
        tx_gap_odds  = 0;
        rx_hold_left = HOLD_CYCLES;
        send_pair(40);
        wait_drained();
        send_pair(12);
    endtask

    task automatic test_random_mix();
        while (rnd_sent < RANDOM_ITEMS) begin
            wait_drained();
            set_random_config();
            tx_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            repeat ($urandom_range(4, 10))
                send_pair(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40));
        end
    endtask

    // Last part of the run with no idling on either side
    task automatic test_quiet_tail();
        wait_drained();
        no_idle = 1'b1;
        set_random_config();
        repeat (4) send_pair($urandom_range(2, 30));
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_single_point();
        test_segments();
        test_uniform();
        test_reserved_mode();
        test_mode_switch();
        test_long_pairs();
        test_backpressure();
        test_random_mix();
        test_quiet_tail();

        // drain with a bound, then let the pipeline settle
        i_valid <= 1'b0;
        for (int n = 0; n < 20000 && offspring_q.size() != 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (offspring_q.size() != 0)
            report_mismatch("results never returned", offspring_q.size(), 0);

        if (err_count == 0) begin
            $display("PASS ga_chromosome_crossover");
        end else begin
            $display("FAIL ga_chromosome_crossover");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("FAIL ga_chromosome_crossover");
        $finish;
    end

endmodule

/* sim.f */
src/gacx_pkg.sv
src/gacx_regs.sv
src/ga_chromosome_crossover.sv
dv/testbench.sv
